### rtl/trm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_pkg: shared constants for the tiny register machine execute block
// Field widths, register file geometry, stream layouts and opcode values.
// ----------------------------------------------------------------------------
package trm_pkg;

  localparam int NUM_REGS   = 16;
  localparam int RIDX_W     = $clog2(NUM_REGS);
  localparam int REG_WIDTH  = 32;
  localparam int PROG_DEPTH = 256;
  localparam int PC_W       = 8;
  localparam int LEN_W      = 9;
  localparam int OFS_W      = 10;
  localparam int BYTE_W     = 8;
  localparam int STEP_W     = 4;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PROG_DEPTH);
  localparam logic [LEN_W-1:0] LEN_RST = LEN_W'(PROG_DEPTH);

  localparam logic [7:0] OP_INC  = 8'h01;
  localparam logic [7:0] OP_DEC  = 8'h02;
  localparam logic [7:0] OP_MOV  = 8'h03;
  localparam logic [7:0] OP_MOVC = 8'h04;
  localparam logic [7:0] OP_LSL  = 8'h05;
  localparam logic [7:0] OP_ASR  = 8'h06;
  localparam logic [7:0] OP_JMP  = 8'h07;
  localparam logic [7:0] OP_JZ   = 8'h08;
  localparam logic [7:0] OP_JNZ  = 8'h09;
  localparam logic [7:0] OP_JFE  = 8'h0a;
  localparam logic [7:0] OP_RET  = 8'h0b;
  localparam logic [7:0] OP_ADD  = 8'h0c;
  localparam logic [7:0] OP_SUB  = 8'h0d;
  localparam logic [7:0] OP_XOR  = 8'h0e;
  localparam logic [7:0] OP_OR   = 8'h0f;
  localparam logic [7:0] OP_READ = 8'h10;
  localparam logic [7:0] OP_OUT  = 8'h11;

  // Output field positions inside out_tdata
  localparam int OUT_PC_LO    = 0;
  localparam int OUT_VALID_B  = 8;
  localparam int OUT_CHAR_LO  = 9;
  localparam int OUT_TAKEN_B  = 17;
  localparam int OUT_HALTED_B = 18;
  localparam int OUT_ZERO_B   = 19;

  function automatic logic [REG_WIDTH-1:0] sext8(input logic [BYTE_W-1:0] b);
    sext8 = {{(REG_WIDTH-BYTE_W){b[BYTE_W-1]}}, b};
  endfunction

endpackage

### rtl/trm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module trm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/tiny_register_machine_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_register_machine_execute: one instruction step per request
// Usage:
//   in_*  : one request = opcode, operand, next input char and empty flag.
//   out_* : one result per request = next_pc, output char, status flags.
//   cfg_* : write of program_length (9 bits), always ready; write only
//           while the block is idle.
// Request flow:
//   Rx and Ry are read in turn from a 16 x 32 register RAM, then one ALU
//   step executes and writes back. A request whose new counter already
//   lies in [0, length) goes from S_EXEC straight to S_FIN, which loads
//   the output register. A counter that wraps first goes through a single
//   compare/subtract unit for 9 restoring steps (S_WRAP) plus one fixup
//   (S_FIX) on its way to S_FIN. A request seen after RET goes from S_IDLE
//   straight to S_FIN. One request is in flight at a time.
// Reset: rst_n clears the registers (per-entry valid bits read as zero),
//   the counter, the zero, end and halt flags, and sets length to 256.
// Stall: a finished result waits in the output register; the next request
//   is taken meanwhile and completes once that register frees.
// ----------------------------------------------------------------------------
module tiny_register_machine_execute (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [7:0] opcode, [15:8] operand, [23:16] in_char, [24] in_empty
  input  logic [trm_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] next_pc, [8] out_valid, [16:9] out_char, [17] input_taken,
  // [18] halted, [19] zero_flag
  output logic [trm_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [trm_pkg::LEN_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_RDX, S_EXEC, S_WRAP, S_FIX, S_FIN} state_t;

  localparam int W  = trm_pkg::REG_WIDTH;
  localparam int RW = trm_pkg::RIDX_W;
  localparam int LW = trm_pkg::LEN_W;
  localparam int PW = trm_pkg::PC_W;
  localparam int SW = 2 * trm_pkg::LEN_W - 1;

  state_t state_r, state_nxt;

  logic [7:0]                  op_r, op_nxt;
  logic [7:0]                  arg_r, arg_nxt;
  logic [7:0]                  ch_r, ch_nxt;
  logic                        empty_r, empty_nxt;
  logic [W-1:0]                rx_r, rx_nxt;
  logic [PW-1:0]               pc_r, pc_nxt;
  logic                        zero_r, zero_nxt;
  logic                        end_r, end_nxt;
  logic                        halt_r, halt_nxt;
  logic [LW-1:0]               len_r, len_nxt;
  logic [trm_pkg::NUM_REGS-1:0] vld_r, vld_nxt;
  logic                        rdv_r;
  logic [LW-1:0]               rem_r, rem_nxt;
  logic                        neg_r, neg_nxt;
  logic [trm_pkg::STEP_W-1:0]  k_r, k_nxt;
  logic                        ov_r, ov_nxt;
  logic [7:0]                  och_r, och_nxt;
  logic                        tk_r, tk_nxt;
  logic                        out_tvalid_r, out_tvalid_nxt;
  logic [trm_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic          in_acc;
  logic [RW-1:0] raddr;
  logic [W-1:0]  rdata, rd_m;
  logic          we;
  logic [RW-1:0] waddr;
  logic [W-1:0]  alu_res;
  logic          setz;
  logic          take;
  logic [LW-1:0] len_eff;
  logic [trm_pkg::OFS_W-1:0] delta, tsum, tneg;
  logic [SW-1:0] sh_div, rem_ext;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign raddr = (state_r == S_IDLE) ? in_tdata[8 +: RW] : arg_r[7:4];
  assign rd_m  = rdv_r ? rdata : '0;
  assign waddr = (op_r == trm_pkg::OP_MOVC) ? RW'(0) : arg_r[RW-1:0];

  trm_ram #(
    .WIDTH (W),
    .DEPTH (trm_pkg::NUM_REGS)
  ) u_regs (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (alu_res),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    if (len_r < trm_pkg::LEN_MIN) begin
      len_eff = trm_pkg::LEN_MIN;
    end else if (len_r > trm_pkg::LEN_MAX) begin
      len_eff = trm_pkg::LEN_MAX;
    end else begin
      len_eff = len_r;
    end
  end

  // ALU on Rx (held) and Ry (from RAM)
  always_comb begin
    alu_res = rx_r;
    we      = 1'b0;
    setz    = 1'b0;
    take    = 1'b0;
    case (op_r)
      trm_pkg::OP_INC:  begin alu_res = rx_r + W'(1); we = 1'b1; setz = 1'b1; end
      trm_pkg::OP_DEC:  begin alu_res = rx_r - W'(1); we = 1'b1; setz = 1'b1; end
      trm_pkg::OP_MOV:  begin alu_res = rd_m; we = 1'b1; end
      trm_pkg::OP_MOVC: begin alu_res = trm_pkg::sext8(arg_r); we = 1'b1; end
      trm_pkg::OP_LSL:  begin alu_res = {rx_r[W-2:0], 1'b0}; we = 1'b1; setz = 1'b1; end
      trm_pkg::OP_ASR:  begin alu_res = {rx_r[W-1], rx_r[W-1:1]}; we = 1'b1; setz = 1'b1; end
      trm_pkg::OP_ADD:  begin alu_res = rx_r + rd_m; we = 1'b1; setz = 1'b1; end
      trm_pkg::OP_SUB:  begin alu_res = rx_r - rd_m; we = 1'b1; setz = 1'b1; end
      trm_pkg::OP_XOR:  begin alu_res = rx_r ^ rd_m; we = 1'b1; setz = 1'b1; end
      trm_pkg::OP_OR:   begin alu_res = rx_r | rd_m; we = 1'b1; setz = 1'b1; end
      trm_pkg::OP_READ: begin alu_res = trm_pkg::sext8(ch_r); we = ~empty_r; end
      trm_pkg::OP_JMP:  take = 1'b1;
      trm_pkg::OP_JZ:   take = zero_r;
      trm_pkg::OP_JNZ:  take = ~zero_r;
      trm_pkg::OP_JFE:  take = end_r;
      default: ;
    endcase
    if (state_r != S_EXEC) begin
      we = 1'b0;
    end
  end

  assign delta   = take ? {{(trm_pkg::OFS_W-8){arg_r[7]}}, arg_r} : trm_pkg::OFS_W'(2);
  assign tsum    = {{(trm_pkg::OFS_W-PW){1'b0}}, pc_r} + delta;
  assign tneg    = -tsum;
  assign sh_div  = {{(SW-LW){1'b0}}, len_eff} << k_r;
  assign rem_ext = {{(SW-LW){1'b0}}, rem_r};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    arg_nxt        = arg_r;
    ch_nxt         = ch_r;
    empty_nxt      = empty_r;
    rx_nxt         = rx_r;
    pc_nxt         = pc_r;
    zero_nxt       = zero_r;
    end_nxt        = end_r;
    halt_nxt       = halt_r;
    len_nxt        = len_r;
    vld_nxt        = vld_r;
    rem_nxt        = rem_r;
    neg_nxt        = neg_r;
    k_nxt          = k_r;
    ov_nxt         = ov_r;
    och_nxt        = och_r;
    tk_nxt         = tk_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;

    if (cfg_valid) begin
      len_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_tdata[7:0];
          arg_nxt   = in_tdata[15:8];
          ch_nxt    = in_tdata[23:16];
          empty_nxt = in_tdata[24];
          ov_nxt    = 1'b0;
          och_nxt   = '0;
          tk_nxt    = 1'b0;
          state_nxt = halt_r ? S_FIN : S_RDX;
        end
      end
      S_RDX: begin
        rx_nxt    = rd_m;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (we) begin
          vld_nxt[waddr] = 1'b1;
        end
        if (setz) begin
          zero_nxt = (alu_res == '0);
        end
        if (op_r == trm_pkg::OP_READ) begin
          tk_nxt = ~empty_r;
          if (empty_r) begin
            end_nxt = 1'b1;
          end
        end
        if (op_r == trm_pkg::OP_OUT) begin
          ov_nxt  = 1'b1;
          och_nxt = rx_r[7:0];
        end
        if (op_r == trm_pkg::OP_RET) begin
          halt_nxt  = 1'b1;
          state_nxt = S_FIN;
        end else if (!tsum[trm_pkg::OFS_W-1] && (tsum[LW-1:0] < len_eff)) begin
          pc_nxt    = tsum[PW-1:0];
          state_nxt = S_FIN;
        end else begin
          neg_nxt   = tsum[trm_pkg::OFS_W-1];
          rem_nxt   = tsum[trm_pkg::OFS_W-1] ? tneg[LW-1:0] : tsum[LW-1:0];
          k_nxt     = trm_pkg::STEP_W'(LW - 1);
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        if (rem_ext >= sh_div) begin
          rem_nxt = rem_r - sh_div[LW-1:0];
        end
        k_nxt = k_r - trm_pkg::STEP_W'(1);
        if (k_r == '0) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        if (neg_r && (rem_r != '0)) begin
          pc_nxt = PW'(len_eff - rem_r);
        end else begin
          pc_nxt = rem_r[PW-1:0];
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {4'b0, zero_r, halt_r, tk_r, och_r, ov_r, pc_r};
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pc_r         <= '0;
      zero_r       <= 1'b0;
      end_r        <= 1'b0;
      halt_r       <= 1'b0;
      len_r        <= trm_pkg::LEN_RST;
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pc_r         <= pc_nxt;
      zero_r       <= zero_nxt;
      end_r        <= end_nxt;
      halt_r       <= halt_nxt;
      len_r        <= len_nxt;
      vld_r        <= vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    op_r        <= op_nxt;
    arg_r       <= arg_nxt;
    ch_r        <= ch_nxt;
    empty_r     <= empty_nxt;
    rx_r        <= rx_nxt;
    rem_r       <= rem_nxt;
    neg_r       <= neg_nxt;
    k_r         <= k_nxt;
    ov_r        <= ov_nxt;
    och_r       <= och_nxt;
    tk_r        <= tk_nxt;
    out_tdata_r <= out_tdata_nxt;
    rdv_r       <= vld_r[raddr];
  end

endmodule

### rtl/trm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_checker: port-level checks for the execute block
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module trm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [trm_pkg::OUT_DATA_W-1:0] out_tdata
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while previous one in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[trm_pkg::OUT_HALTED_B]) |->
      (!out_tdata[trm_pkg::OUT_VALID_B] && !out_tdata[trm_pkg::OUT_TAKEN_B]))
    else $error("halted result reports activity");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[trm_pkg::OUT_VALID_B]) |->
      (out_tdata[trm_pkg::OUT_CHAR_LO +: 8] == 8'h00))
    else $error("output char set without output flag");

endmodule

bind tiny_register_machine_execute trm_checker u_trm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### verif/trm_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_step_checker: scoreboard for the tiny register machine execute block
// Watches the request, result and length-write channels and keeps its own
// copy of the machine state: registers, counter, zero/end/halt flags and the
// program length. It works out the result of every accepted request, queues
// it in order, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module trm_step_checker
  import trm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [LEN_W-1:0]      cfg_data,
  output int                    mismatches,
  output int                    pending
);

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic              out_valid;
    logic [BYTE_W-1:0] out_char;
    logic              input_taken;
    logic              halted;
    logic              zero_flag;
  } step_result_t;

  logic [REG_WIDTH-1:0] regs [NUM_REGS];
  logic [PC_W-1:0]      pc;
  logic                 zero_q;
  logic                 end_q;
  logic                 halt_q;
  logic [LEN_W-1:0]     plen;
  step_result_t         step_results_q [$];

  function automatic step_result_t exec_step(input logic [7:0] op, input logic [7:0] arg,
                                             input logic [7:0] ch, input logic empty);
    step_result_t         r;
    logic [3:0]           x;
    logic [3:0]           y;
    logic [REG_WIDTH-1:0] ry;
    logic                 jump;
    logic                 take;
    logic                 setz;
    int                   n;
    int                   t;
    int                   delta;
    r    = '0;
    x    = arg[3:0];
    y    = arg[7:4];
    jump = 1'b0;
    take = 1'b0;
    setz = 1'b0;
    if (!halt_q) begin
      ry = regs[y];
      case (op)
        OP_INC:  begin regs[x] = regs[x] + 1'b1; setz = 1'b1; end
        OP_DEC:  begin regs[x] = regs[x] - 1'b1; setz = 1'b1; end
        OP_MOV:  regs[x] = ry;
        OP_MOVC: regs[0] = {{(REG_WIDTH-BYTE_W){arg[7]}}, arg};
        OP_LSL:  begin regs[x] = regs[x] << 1; setz = 1'b1; end
        OP_ASR:  begin regs[x] = {regs[x][REG_WIDTH-1], regs[x][REG_WIDTH-1:1]}; setz = 1'b1; end
        OP_JMP:  begin jump = 1'b1; take = 1'b1; end
        OP_JZ:   begin jump = 1'b1; take = zero_q; end
        OP_JNZ:  begin jump = 1'b1; take = !zero_q; end
        OP_JFE:  begin jump = 1'b1; take = end_q; end
        OP_RET:  halt_q = 1'b1;
        OP_ADD:  begin regs[x] = regs[x] + ry; setz = 1'b1; end
        OP_SUB:  begin regs[x] = regs[x] - ry; setz = 1'b1; end
        OP_XOR:  begin regs[x] = regs[x] ^ ry; setz = 1'b1; end
        OP_OR:   begin regs[x] = regs[x] | ry; setz = 1'b1; end
        OP_READ: begin
          if (!empty) begin
            regs[x] = {{(REG_WIDTH-BYTE_W){ch[7]}}, ch};
            r.input_taken = 1'b1;
          end else begin
            end_q = 1'b1;
          end
        end
        OP_OUT: begin
          r.out_valid = 1'b1;
          r.out_char  = regs[x][7:0];
        end
        default: ;
      endcase
      if (setz) zero_q = (regs[x] == '0);
      if (!halt_q) begin
        delta = (jump && take) ? int'($signed(arg)) : 2;
        n = (plen < LEN_MIN) ? int'(LEN_MIN) : (plen > LEN_MAX) ? int'(LEN_MAX) : int'(plen);
        t = (int'(pc) + delta) % n;
        if (t < 0) t += n;
        pc = t[PC_W-1:0];
      end
    end
    r.next_pc   = pc;
    r.halted    = halt_q;
    r.zero_flag = zero_q;
    return r;
  endfunction

  function automatic int field_diff(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    step_result_t want;
    step_result_t got;
    int           errs;
    errs = mismatches;
    if (!rst_n) begin
      foreach (regs[i]) regs[i] = '0;
      pc     = '0;
      zero_q = 1'b0;
      end_q  = 1'b0;
      halt_q = 1'b0;
      plen   = LEN_RST;
      step_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) plen = cfg_data;
      if (in_tvalid && in_tready)
        step_results_q.push_back(exec_step(in_tdata[7:0], in_tdata[15:8],
                                           in_tdata[23:16], in_tdata[24]));
      if (out_tvalid && out_tready) begin
        got.next_pc     = out_tdata[OUT_PC_LO +: PC_W];
        got.out_valid   = out_tdata[OUT_VALID_B];
        got.out_char    = out_tdata[OUT_CHAR_LO +: BYTE_W];
        got.input_taken = out_tdata[OUT_TAKEN_B];
        got.halted      = out_tdata[OUT_HALTED_B];
        got.zero_flag   = out_tdata[OUT_ZERO_B];
        if (step_results_q.size() == 0) begin
          $error("out_tdata: result 0x%0h with no request outstanding", out_tdata);
          errs++;
        end else begin
          want = step_results_q.pop_front();
          errs += field_diff("next_pc", want.next_pc, got.next_pc);
          errs += field_diff("out_valid", want.out_valid, got.out_valid);
          errs += field_diff("out_char", want.out_char, got.out_char);
          errs += field_diff("input_taken", want.input_taken, got.input_taken);
          errs += field_diff("halted", want.halted, got.halted);
          errs += field_diff("zero_flag", want.zero_flag, got.zero_flag);
        end
      end
    end
    mismatches <= errs;
    pending    <= step_results_q.size();
  end

endmodule

### verif/tb_tiny_register_machine_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tiny_register_machine_execute: stimulus and verdict for the execute block
// Directed opening over each opcode but RET and corners, then phases of random
// instruction streams, each under its own program length (clamped, wrapping
// and shrinking values included), with random idle gaps on both channels and
// one long result back-pressure. The machine is halted only at the very end.
// ----------------------------------------------------------------------------
module tb_tiny_register_machine_execute;
  import trm_pkg::*;

  localparam logic [7:0] OP_UNUSED  = 8'h00;
  localparam int         PHASE_LEN  = 106;
  localparam int         LONG_HOLD  = 200;
  localparam int         DRAIN_WAIT = 20;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [LEN_W-1:0]      cfg_data   = '0;

  int mismatches;
  int pending;
  int phase_no = 0;
  bit no_idle  = 1'b0;
  bit held_long = 1'b0;

  always #5 clk = ~clk;

  tiny_register_machine_execute u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  trm_step_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  function automatic logic [IN_DATA_W-1:0] instr(input logic [7:0] op, input logic [7:0] arg,
                                                 input logic [7:0] ch, input logic empty);
    return {7'b0, empty, ch, arg, op};
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_instr();
    logic [7:0] op;
    logic [7:0] arg;
    logic [7:0] ch;
    logic       empty;
    int         r;
    r     = $urandom_range(0, 99);
    arg   = 8'($urandom_range(0, 255));
    ch    = 8'($urandom_range(0, 255));
    empty = 1'($urandom_range(0, 1));
    if (r < 6) begin
      op = 8'($urandom_range(OP_OUT + 1, 255));
    end else if (r < 8) begin
      op = OP_UNUSED;
    end else begin
      case ($urandom_range(0, 15))
        0:       op = OP_INC;
        1:       op = OP_DEC;
        2:       op = OP_MOV;
        3:       op = OP_MOVC;
        4:       op = OP_LSL;
        5:       op = OP_ASR;
        6:       op = OP_JMP;
        7:       op = OP_JZ;
        8:       op = OP_JNZ;
        9:       op = OP_JFE;
        10:      op = OP_ADD;
        11:      op = OP_SUB;
        12:      op = OP_XOR;
        13:      op = OP_OR;
        14:      op = OP_READ;
        default: op = OP_OUT;
      endcase
    end
    if ((op == OP_SUB || op == OP_XOR || op == OP_MOV) && $urandom_range(0, 3) == 0)
      arg[7:4] = arg[3:0];
    if (op == OP_READ) empty = ($urandom_range(0, 9) == 0);
    return instr(op, arg, ch, empty);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // hold the request until accepted; valid stays high unless a gap follows
  task automatic send_instr(input logic [IN_DATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // result side: short random stalls, one long hold early on
  initial begin : result_sink
    int r;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (phase_no == 2 && !held_long) begin
        held_long = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          repeat (r < 97 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
          out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin : limit
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    logic [LEN_W-1:0] lengths [$];
    lengths = '{9'd0, 9'd511, 9'd1, 9'd2, 9'd3, 9'd257, 9'd17, 9'd255, 9'd5, 9'd256, 9'd100};
    lengths.push_back(LEN_W'($urandom_range(2, 256)));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening at the reset length
    send_instr(instr(OP_MOVC, 8'h7f, 8'h00, 1'b0));
    send_instr(instr(OP_MOVC, 8'h80, 8'h00, 1'b0));
    send_instr(instr(OP_INC,  8'h00, 8'h00, 1'b0));
    send_instr(instr(OP_DEC,  8'h01, 8'h00, 1'b0));
    send_instr(instr(OP_INC,  8'h01, 8'h00, 1'b0));
    send_instr(instr(OP_JZ,   8'h06, 8'h00, 1'b0));
    send_instr(instr(OP_JNZ,  8'h10, 8'h00, 1'b0));
    send_instr(instr(OP_LSL,  8'h00, 8'h00, 1'b0));
    send_instr(instr(OP_ASR,  8'h00, 8'h00, 1'b0));
    send_instr(instr(OP_MOV,  8'h02, 8'h00, 1'b0));
    send_instr(instr(OP_ADD,  8'h02, 8'h00, 1'b0));
    send_instr(instr(OP_SUB,  8'h22, 8'h00, 1'b0));
    send_instr(instr(OP_XOR,  8'h03, 8'h00, 1'b0));
    send_instr(instr(OP_OR,   8'h23, 8'h00, 1'b0));
    send_instr(instr(OP_READ, 8'h04, 8'hff, 1'b0));
    send_instr(instr(OP_READ, 8'h05, 8'h00, 1'b0));
    send_instr(instr(OP_OUT,  8'h04, 8'h00, 1'b0));
    send_instr(instr(OP_JFE,  8'h04, 8'h00, 1'b0));
    send_instr(instr(OP_READ, 8'hf6, 8'h5a, 1'b1));
    send_instr(instr(OP_JFE,  8'hfe, 8'h00, 1'b0));
    send_instr(instr(OP_JMP,  8'h80, 8'h00, 1'b0));
    send_instr(instr(OP_JMP,  8'h7f, 8'h00, 1'b0));
    send_instr(instr(8'hff,   8'hff, 8'hff, 1'b1));
    send_instr(instr(OP_UNUSED, 8'h00, 8'h00, 1'b0));
    send_instr(instr(OP_INC,  8'h0f, 8'h00, 1'b0));
    drain();

    foreach (lengths[p]) begin
      phase_no = p + 1;
      no_idle  = (phase_no % 4 == 2);
      write_length(lengths[p]);
      repeat (PHASE_LEN) send_instr(random_instr());
      drain();
    end

    // halt, then confirm nothing moves
    phase_no = 0;
    no_idle  = 1'b0;
    send_instr(instr(OP_RET, 8'($urandom_range(0, 255)), 8'h00, 1'b0));
    send_instr(instr(OP_OUT, 8'h04, 8'h00, 1'b0));
    send_instr(instr(OP_READ, 8'h06, 8'h41, 1'b0));
    send_instr(instr(OP_JMP, 8'h10, 8'h00, 1'b0));
    send_instr(random_instr());
    drain();

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
rtl/trm_pkg.sv
rtl/trm_ram.sv
rtl/tiny_register_machine_execute.sv
rtl/trm_checker.sv
verif/trm_step_checker.sv
verif/tb_tiny_register_machine_execute.sv
